/* rtl/rcsp_pkg.sv */
// Shared types and constants for the request stream parser.
`timescale 1ns / 1ps
package rcsp_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 32;
   localparam int NUM_BITS    = 32;
   localparam int ARGS_BITS   = 16;
   localparam int ARGLEN_BITS = 31;
   localparam int CSR_BITS    = 31;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [ARGS_BITS-1:0]   MAX_ARGS_RST   = ARGS_BITS'(1024);
   localparam logic [ARGLEN_BITS-1:0] MAX_ARGLEN_RST = ARGLEN_BITS'(1048576);

   typedef enum logic {
      CSR_MAX_ARGS    = 1'b0,
      CSR_MAX_ARG_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_STAR   = 3'd0,
      PH_COUNT  = 3'd1,
      PH_DOLLAR = 3'd2,
      PH_LENGTH = 3'd3,
      PH_DATA   = 3'd4,
      PH_CR     = 3'd5,
      PH_LF     = 3'd6,
      PH_ERROR  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ERR_BAD_STAR   = 3'd0,
      ERR_BAD_COUNT  = 3'd1,
      ERR_BAD_DOLLAR = 3'd2,
      ERR_NEG_LENGTH = 3'd3,
      ERR_NO_CRLF    = 3'd4,
      ERR_LIMIT      = 3'd5
   } err_code_type;

   typedef struct packed {
      logic                started;
      logic                neg;
      logic                stopped;
      logic                crpend;
      logic [NUM_BITS-1:0] accum;
   } num_type;

endpackage

/* rtl/rcsp_ifs.sv */
// Valid/ready stream interfaces for request bytes and parser results.
`timescale 1ns / 1ps
interface rcsp_req_if;
   import rcsp_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface rcsp_rsp_if;
   import rcsp_pkg::*;
   logic        valid;
   logic        ready;
   logic        data_valid;
   logic [7:0]  payload_byte;
   logic [15:0] arg_index;
   logic        arg_end;
   logic        command_end;
   logic [15:0] arg_count;
   logic        error_flag;
   logic [2:0]  error_code;
   modport source (output valid, output data_valid, output payload_byte, output arg_index,
                   output arg_end, output command_end, output arg_count,
                   output error_flag, output error_code, input ready);
   modport sink (input valid, input data_valid, input payload_byte, input arg_index,
                 input arg_end, input command_end, input arg_count,
                 input error_flag, input error_code, output ready);
endinterface

/* rtl/resp_command_stream_parser.sv */
// Top level: byte-serial parser for star/dollar framed request commands.
//
// Usage:
//   req_bus carries one raw byte of the request stream per transfer.
//   rsp_bus carries at most one result per byte: a payload byte tagged
//   with its argument index, an end-of-argument mark (with command end on
//   the last argument), or the sticky error result with its code.
//   Marker bytes, count and length lines and the payload CR give no result.
//   csr_wr_en/csr_index/csr_wdata write max_args (index 0) and
//   max_arg_length (index 1); write only while the parser is idle.
// Timing:
//   One byte per cycle unless rsp_bus stalls; a result is valid on rsp_bus
//   in the cycle after its byte's transfer, held in one output register.
//   The per-byte state update is short combinational logic ahead of it.
// Reset:
//   Synchronous reset clears the parser to wait for a star marker and
//   restores the limit registers to 1024 and 1048576. Only reset leaves the
//   error state.
// Stall:
//   While a result waits on rsp_bus with ready low, req_bus.ready is low.
`timescale 1ns / 1ps
module resp_command_stream_parser (
   input  logic                            clock,
   input  logic                            reset,
   rcsp_req_if.sink                        req_bus,
   rcsp_rsp_if.source                      rsp_bus,
   input  logic                            csr_wr_en,
   input  rcsp_pkg::csr_index_type         csr_index,
   input  logic [rcsp_pkg::CSR_BITS-1:0]   csr_wdata
);
   import rcsp_pkg::*;

   localparam logic [NUM_BITS:0] CNT_CAP = (33'(1) << COUNT_BITS) - 33'(1);
   localparam logic [NUM_BITS:0] LEN_CAP = (33'(1) << LENGTH_BITS) - 33'(1);

   function automatic num_type feed_number(num_type n_cur, logic [7:0] c);
      num_type           n;
      logic              digit;
      logic              blank;
      logic [NUM_BITS+3:0] prod;
      n     = n_cur;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      prod  = ({4'b0, n.accum} << 3) + ({4'b0, n.accum} << 1)
              + (NUM_BITS+4)'(c - CH_ZERO);
      if (!n.stopped) begin
         if (!n.started && blank) begin
            n = n_cur;
         end else if (!n.started && ((c == CH_PLUS) || (c == CH_MINUS))) begin
            n.started = 1'b1;
            n.neg     = (c == CH_MINUS);
         end else begin
            n.started = 1'b1;
            if (digit) begin
               if (prod[NUM_BITS+3:NUM_BITS] != 4'b0) begin
                  n.accum = '1;
               end else begin
                  n.accum = prod[NUM_BITS-1:0];
               end
            end else begin
               n.stopped = 1'b1;
            end
         end
      end
      return n;
   endfunction

   logic [ARGS_BITS-1:0]   max_args_ff;
   logic [ARGLEN_BITS-1:0] max_arg_len_ff;

   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  expected_args_ff, expected_args_in;
   logic [COUNT_BITS-1:0]  current_arg_ff, current_arg_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   num_type                num_ff, num_in;
   err_code_type           err_ff, err_in;

   num_type                line_num;
   logic                   line_done;
   logic [COUNT_BITS:0]    arg_next;
   logic [7:0]             c;

   logic                   res_emit;
   logic                   res_dv;
   logic [7:0]             res_pb;
   logic [15:0]            res_idx;
   logic                   res_ae;
   logic                   res_ce;
   logic [15:0]            res_cnt;
   logic                   res_err;
   err_code_type           res_code;

   logic                   req_accept;
   logic                   rsp_valid_ff;
   logic                   rsp_dv_ff;
   logic [7:0]             rsp_pb_ff;
   logic [15:0]            rsp_idx_ff;
   logic                   rsp_ae_ff;
   logic                   rsp_ce_ff;
   logic [15:0]            rsp_cnt_ff;
   logic                   rsp_err_ff;
   err_code_type           rsp_code_ff;

   assign c          = req_bus.byte_in;
   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign arg_next   = {1'b0, current_arg_ff} + (COUNT_BITS+1)'(1);

   always_comb begin
      line_num  = num_ff;
      line_done = 1'b0;
      if (num_ff.crpend && (c == CH_LF)) begin
         line_done = 1'b1;
      end else begin
         if (line_num.crpend) begin
            line_num.crpend = 1'b0;
            line_num = feed_number(line_num, CH_CR);
         end
         if (c == CH_CR) begin
            line_num.crpend = 1'b1;
         end else begin
            line_num = feed_number(line_num, c);
         end
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      expected_args_in = expected_args_ff;
      current_arg_in   = current_arg_ff;
      bytes_left_in    = bytes_left_ff;
      num_in           = num_ff;
      err_in           = err_ff;
      res_emit         = 1'b0;
      res_dv           = 1'b0;
      res_pb           = '0;
      res_idx          = 16'(current_arg_ff);
      res_ae           = 1'b0;
      res_ce           = 1'b0;
      res_cnt          = 16'(expected_args_ff);
      res_err          = 1'b0;
      res_code         = ERR_BAD_STAR;
      unique case (phase_ff)
         PH_STAR: begin
            if (c == CH_STAR) begin
               phase_in = PH_COUNT;
               num_in   = '0;
            end else begin
               phase_in = PH_ERROR;
               err_in   = ERR_BAD_STAR;
            end
         end
         PH_COUNT: begin
            if (line_done) begin
               if ((num_ff.accum == '0) || num_ff.neg) begin
                  phase_in = PH_ERROR;
                  err_in   = ERR_BAD_COUNT;
               end else if (({1'b0, num_ff.accum} > (NUM_BITS+1)'(max_args_ff))
                            || ({1'b0, num_ff.accum} > CNT_CAP)) begin
                  phase_in = PH_ERROR;
                  err_in   = ERR_LIMIT;
               end else begin
                  expected_args_in = num_ff.accum[COUNT_BITS-1:0];
                  current_arg_in   = '0;
                  phase_in         = PH_DOLLAR;
               end
            end else begin
               num_in = line_num;
            end
         end
         PH_DOLLAR: begin
            if (c == CH_DOLLAR) begin
               phase_in = PH_LENGTH;
               num_in   = '0;
            end else begin
               phase_in = PH_ERROR;
               err_in   = ERR_BAD_DOLLAR;
            end
         end
         PH_LENGTH: begin
            if (line_done) begin
               if (num_ff.neg && (num_ff.accum != '0)) begin
                  phase_in = PH_ERROR;
                  err_in   = ERR_NEG_LENGTH;
               end else if (({1'b0, num_ff.accum} > (NUM_BITS+1)'(max_arg_len_ff))
                            || ({1'b0, num_ff.accum} > LEN_CAP)) begin
                  phase_in = PH_ERROR;
                  err_in   = ERR_LIMIT;
               end else begin
                  bytes_left_in = num_ff.accum[LENGTH_BITS-1:0];
                  phase_in      = (num_ff.accum != '0) ? PH_DATA : PH_CR;
               end
            end else begin
               num_in = line_num;
            end
         end
         PH_DATA: begin
            res_emit      = 1'b1;
            res_dv        = 1'b1;
            res_pb        = c;
            bytes_left_in = bytes_left_ff - LENGTH_BITS'(1);
            if (bytes_left_ff == LENGTH_BITS'(1)) begin
               phase_in = PH_CR;
            end
         end
         PH_CR: begin
            if (c == CH_CR) begin
               phase_in = PH_LF;
            end else begin
               phase_in = PH_ERROR;
               err_in   = ERR_NO_CRLF;
            end
         end
         PH_LF: begin
            if (c != CH_LF) begin
               phase_in = PH_ERROR;
               err_in   = ERR_NO_CRLF;
            end else begin
               res_emit = 1'b1;
               res_ae   = 1'b1;
               if (arg_next >= {1'b0, expected_args_ff}) begin
                  res_ce           = 1'b1;
                  phase_in         = PH_STAR;
                  expected_args_in = '0;
                  current_arg_in   = '0;
                  bytes_left_in    = '0;
               end else begin
                  current_arg_in = arg_next[COUNT_BITS-1:0];
                  phase_in       = PH_DOLLAR;
               end
            end
         end
         PH_ERROR: begin
            phase_in = PH_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
      if (phase_in == PH_ERROR) begin
         res_emit = 1'b1;
         res_dv   = 1'b0;
         res_pb   = '0;
         res_ae   = 1'b0;
         res_ce   = 1'b0;
         res_idx  = 16'(current_arg_in);
         res_cnt  = 16'(expected_args_in);
         res_err  = 1'b1;
         res_code = err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff    <= MAX_ARGS_RST;
         max_arg_len_ff <= MAX_ARGLEN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_ARGS:    max_args_ff    <= csr_wdata[ARGS_BITS-1:0];
            CSR_MAX_ARG_LEN: max_arg_len_ff <= csr_wdata[ARGLEN_BITS-1:0];
            default:         max_args_ff    <= max_args_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STAR;
         expected_args_ff <= '0;
         current_arg_ff   <= '0;
         bytes_left_ff    <= '0;
         num_ff           <= '0;
         err_ff           <= ERR_BAD_STAR;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         expected_args_ff <= expected_args_in;
         current_arg_ff   <= current_arg_in;
         bytes_left_ff    <= bytes_left_in;
         num_ff           <= num_in;
         err_ff           <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && res_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_emit) begin
         rsp_dv_ff   <= res_dv;
         rsp_pb_ff   <= res_pb;
         rsp_idx_ff  <= res_idx;
         rsp_ae_ff   <= res_ae;
         rsp_ce_ff   <= res_ce;
         rsp_cnt_ff  <= res_cnt;
         rsp_err_ff  <= res_err;
         rsp_code_ff <= res_code;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.data_valid   = rsp_dv_ff;
   assign rsp_bus.payload_byte = rsp_pb_ff;
   assign rsp_bus.arg_index    = rsp_idx_ff;
   assign rsp_bus.arg_end      = rsp_ae_ff;
   assign rsp_bus.command_end  = rsp_ce_ff;
   assign rsp_bus.arg_count    = rsp_cnt_ff;
   assign rsp_bus.error_flag   = rsp_err_ff;
   assign rsp_bus.error_code   = rsp_err_ff ? 3'(rsp_code_ff) : 3'b000;

`ifndef SYNTH
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("parser left the error state without reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken while result is stalled");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_dv_ff, rsp_ae_ff, rsp_err_ff}) == 1)
      else $error("result is not exactly one of payload, argument end, error");

   a_arg_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DOLLAR || phase_ff == PH_LENGTH || phase_ff == PH_DATA
       || phase_ff == PH_CR || phase_ff == PH_LF)
      |-> current_arg_ff < expected_args_ff)
      else $error("argument index beyond command argument count");
`endif

endmodule
